### rtl/wgb_pkg.sv
`default_nettype none
package wgb_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned BLEND_W = 9;
  localparam int unsigned CHAN_W  = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned PROD_W  = 24;
  localparam int unsigned MIX_W   = 17;

  localparam logic [15:0] LUMA_WEIGHT_RED   = 16'd13933;
  localparam logic [15:0] LUMA_WEIGHT_GREEN = 16'd46871;
  localparam logic [15:0] LUMA_WEIGHT_BLUE  = 16'd4732;

  localparam logic [BLEND_W-1:0] BLEND_FULL = 9'd256;
  localparam logic [CHAN_W-1:0]  CHAN_RGB   = 3'd3;
  localparam logic [CHAN_W-1:0]  CHAN_RGBA  = 3'd4;
  localparam logic [BLEND_W-1:0] BLEND_RESET = 9'd256;
  localparam logic [CHAN_W-1:0]  CHAN_RESET  = 3'd3;
  localparam logic [PIX_W-1:0]   LUMA_MAX    = 8'd254;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLEND_AMOUNT  = 1'b0,
    CFG_CHANNEL_COUNT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
  } pixel_t;

endpackage
`default_nettype wire

### rtl/wgb_in_if.sv
`default_nettype none
interface wgb_in_if;
  logic                      valid;
  logic                      ready;
  logic [wgb_pkg::PIX_W-1:0] red_in;
  logic [wgb_pkg::PIX_W-1:0] green_in;
  logic [wgb_pkg::PIX_W-1:0] blue_in;
  logic [wgb_pkg::PIX_W-1:0] alpha_in;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface
`default_nettype wire

### rtl/wgb_out_if.sv
`default_nettype none
interface wgb_out_if;
  logic                      valid;
  logic                      ready;
  logic [wgb_pkg::PIX_W-1:0] red_out;
  logic [wgb_pkg::PIX_W-1:0] green_out;
  logic [wgb_pkg::PIX_W-1:0] blue_out;
  logic [wgb_pkg::PIX_W-1:0] alpha_out;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface
`default_nettype wire

### rtl/weighted_grayscale_blend_unit.sv
// Rec.709 grayscale blend, one RGBA pixel per request.
// in_chan carries one pixel request (red, green, blue, alpha) per valid/ready
// handshake; out_chan returns the blended pixel with alpha copied through.
// cfg_we/cfg_idx/cfg_data write blend_amount (index 0, Q1.8, values above 256
// act as 256) and channel_count (index 1; the pixel converts only at 3 or 4,
// else it passes unchanged). Write configuration only while the block is idle.
// Four register stages: weight products, luma sum, blend products, final sum
// into the output register; a request leaves after it has passed all four.
// Throughput is one pixel per cycle while out_chan.ready stays high; each
// stage advances on its own, so a stage that is empty accepts new data even
// while the output register holds. Reset (rst_n low, synchronous) empties
// all stages and loads blend_amount 256 and channel_count 3. When the
// receiver stalls, the output holds its pixel and the stages behind it fill;
// in_chan.ready drops only when all four are full and out_chan.ready is low.
// Nothing is lost or repeated.
`default_nettype none
module weighted_grayscale_blend_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  wgb_in_if.sink                              in_chan,
  wgb_out_if.source                           out_chan,
  input  wire logic                           cfg_we,
  input  wire logic [wgb_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [wgb_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [wgb_pkg::BLEND_W-1:0] blend_amount_r;
  logic [wgb_pkg::CHAN_W-1:0]  channel_count_r;

  logic [wgb_pkg::BLEND_W-1:0] p_sat;
  logic                        conv;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  wgb_pkg::pixel_t             pix1_r, pix2_r, pix3_r, pix4_r;
  logic                        conv1_r, conv2_r, conv3_r;
  logic [wgb_pkg::BLEND_W-1:0] p1_r, p2_r;
  logic [wgb_pkg::PROD_W-1:0]  prod_r_r, prod_g_r, prod_b_r;
  logic [wgb_pkg::PROD_W-1:0]  prod_r_nxt, prod_g_nxt, prod_b_nxt;
  logic [wgb_pkg::PIX_W-1:0]   luma2_r, luma2_nxt;
  logic [wgb_pkg::MIX_W-1:0]   mix_l3_r;
  logic [wgb_pkg::MIX_W-1:0]   mix_r3_r, mix_g3_r, mix_b3_r;
  logic [wgb_pkg::MIX_W-1:0]   mix_l3_nxt, mix_r3_nxt, mix_g3_nxt, mix_b3_nxt;
  logic [wgb_pkg::BLEND_W-1:0] q2;
  logic [wgb_pkg::MIX_W-1:0]   sum_r, sum_g, sum_b;
  wgb_pkg::pixel_t             pix4_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_amount_r  <= wgb_pkg::BLEND_RESET;
      channel_count_r <= wgb_pkg::CHAN_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        wgb_pkg::CFG_BLEND_AMOUNT:  blend_amount_r  <= cfg_data[wgb_pkg::BLEND_W-1:0];
        wgb_pkg::CFG_CHANNEL_COUNT: channel_count_r <= cfg_data[wgb_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  assign p_sat = (blend_amount_r > wgb_pkg::BLEND_FULL) ? wgb_pkg::BLEND_FULL
                                                        : blend_amount_r;
  assign conv  = (channel_count_r == wgb_pkg::CHAN_RGB) ||
                 (channel_count_r == wgb_pkg::CHAN_RGBA);

  assign rdy4 = !v4_r || out_chan.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_chan.ready = rdy1;

  assign prod_r_nxt = wgb_pkg::PROD_W'(in_chan.red_in) *
                      wgb_pkg::PROD_W'(wgb_pkg::LUMA_WEIGHT_RED);
  assign prod_g_nxt = wgb_pkg::PROD_W'(in_chan.green_in) *
                      wgb_pkg::PROD_W'(wgb_pkg::LUMA_WEIGHT_GREEN);
  assign prod_b_nxt = wgb_pkg::PROD_W'(in_chan.blue_in) *
                      wgb_pkg::PROD_W'(wgb_pkg::LUMA_WEIGHT_BLUE);

  assign luma2_nxt = wgb_pkg::PIX_W'(
                       {2'b00, prod_r_r[wgb_pkg::PROD_W-1:16]} +
                       {2'b00, prod_g_r[wgb_pkg::PROD_W-1:16]} +
                       {2'b00, prod_b_r[wgb_pkg::PROD_W-1:16]});

  assign q2 = wgb_pkg::BLEND_FULL - p2_r;
  assign mix_l3_nxt = wgb_pkg::MIX_W'(p2_r) * wgb_pkg::MIX_W'(luma2_r);
  assign mix_r3_nxt = wgb_pkg::MIX_W'(q2) * wgb_pkg::MIX_W'(pix2_r.red);
  assign mix_g3_nxt = wgb_pkg::MIX_W'(q2) * wgb_pkg::MIX_W'(pix2_r.green);
  assign mix_b3_nxt = wgb_pkg::MIX_W'(q2) * wgb_pkg::MIX_W'(pix2_r.blue);

  assign sum_r = mix_l3_r + mix_r3_r;
  assign sum_g = mix_l3_r + mix_g3_r;
  assign sum_b = mix_l3_r + mix_b3_r;

  always_comb begin
    pix4_nxt = pix3_r;
    if (conv3_r) begin
      pix4_nxt.red   = sum_r[15:8];
      pix4_nxt.green = sum_g[15:8];
      pix4_nxt.blue  = sum_b[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_chan.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      pix1_r   <= '{in_chan.red_in, in_chan.green_in, in_chan.blue_in, in_chan.alpha_in};
      conv1_r  <= conv;
      p1_r     <= p_sat;
      prod_r_r <= prod_r_nxt;
      prod_g_r <= prod_g_nxt;
      prod_b_r <= prod_b_nxt;
    end
    if (rdy2) begin
      pix2_r  <= pix1_r;
      conv2_r <= conv1_r;
      p2_r    <= p1_r;
      luma2_r <= luma2_nxt;
    end
    if (rdy3) begin
      pix3_r   <= pix2_r;
      conv3_r  <= conv2_r;
      mix_l3_r <= mix_l3_nxt;
      mix_r3_r <= mix_r3_nxt;
      mix_g3_r <= mix_g3_nxt;
      mix_b3_r <= mix_b3_nxt;
    end
    if (rdy4) begin
      pix4_r <= pix4_nxt;
    end
  end

  assign out_chan.valid     = v4_r;
  assign out_chan.red_out   = pix4_r.red;
  assign out_chan.green_out = pix4_r.green;
  assign out_chan.blue_out  = pix4_r.blue;
  assign out_chan.alpha_out = pix4_r.alpha;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !v1_r && !v2_r && !v3_r && !v4_r)
    else $error("pipeline not empty after reset");

  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready == (!v1_r || !v2_r || !v3_r || !v4_r || out_chan.ready))
    else $error("input ready disagrees with stage occupancy");

  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> luma2_r <= wgb_pkg::LUMA_MAX)
    else $error("luma out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !out_chan.ready |=> v4_r && $stable(pix4_r))
    else $error("stalled output pixel changed");

endmodule
`default_nettype wire
